// File: rtl/core/triggered_waveform_sequencer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triggered waveform sequencer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRIGGERED_WAVEFORM_SEQUENCER_DEFINES_SVH
`define TRIGGERED_WAVEFORM_SEQUENCER_DEFINES_SVH

// Same-cycle implication
`define TWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tws_pkg.sv
// ---------------------------------------------------------------------------
// Triggered waveform sequencer package
// Sizing constants, fixed-point constants and the configuration bundle.
// ---------------------------------------------------------------------------
package tws_pkg;

  // Table and resolution sizing
  localparam int TABLE_DEPTH = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int TICK_BITS   = 24;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);

  // Playback length cap: the count field and the table both bound it
  localparam int COUNT_CAP_INT = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
  localparam logic [16:0] COUNT_CAP = 17'(COUNT_CAP_INT);

  // Fixed-point constants
  localparam logic [15:0] FULL_SCALE    = 16'd32768;
  localparam logic [15:0] FIXED_Z       = 16'd6554;   // 0.2 m in Q1.15
  localparam logic [16:0] DEFAULT_COUNT = 17'd40000;
  localparam logic [15:0] KEEP_MASK     = 16'(16'hFFFF << (16 - SAMPLE_BITS));
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [16:0] sample_count;
    logic        trigger_enable;
    logic [23:0] trigger_period_ticks;
    logic [23:0] trigger_rise_ticks;
    logic [23:0] trigger_fall_ticks;
  } cfg_t;

endpackage

// File: rtl/core/tws_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module tws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/tws_regs.sv
// ---------------------------------------------------------------------------
// Triggered waveform sequencer register bank
// APB-style configuration registers with read-back; always ready.
// ---------------------------------------------------------------------------
module tws_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tws_pkg::cfg_t      cfg
);

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT   = 3'd0,
    REG_TRIGGER_ENABLE = 3'd1,
    REG_TRIGGER_PERIOD = 3'd2,
    REG_TRIGGER_RISE   = 3'd3,
    REG_TRIGGER_FALL   = 3'd4
  } reg_idx_t;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // Hold the registers, update on a completed write beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count         <= tws_pkg::DEFAULT_COUNT;
      cfg.trigger_enable       <= 1'b0;
      cfg.trigger_period_ticks <= '0;
      cfg.trigger_rise_ticks   <= '0;
      cfg.trigger_fall_ticks   <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_SAMPLE_COUNT:   cfg.sample_count         <= pwdata[16:0];
        REG_TRIGGER_ENABLE: cfg.trigger_enable       <= pwdata[0];
        REG_TRIGGER_PERIOD: cfg.trigger_period_ticks <= pwdata[23:0];
        REG_TRIGGER_RISE:   cfg.trigger_rise_ticks   <= pwdata[23:0];
        REG_TRIGGER_FALL:   cfg.trigger_fall_ticks   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (paddr[4:2])
      REG_SAMPLE_COUNT:   prdata = 32'(cfg.sample_count);
      REG_TRIGGER_ENABLE: prdata = 32'(cfg.trigger_enable);
      REG_TRIGGER_PERIOD: prdata = 32'(cfg.trigger_period_ticks);
      REG_TRIGGER_RISE:   prdata = 32'(cfg.trigger_rise_ticks);
      REG_TRIGGER_FALL:   prdata = 32'(cfg.trigger_fall_ticks);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/triggered_waveform_sequencer.sv
// ---------------------------------------------------------------------------
// Triggered waveform sequencer
// Plays a stored table of intensity and position samples, one per tick.
// ---------------------------------------------------------------------------
// The block takes one input beat every clock cycle: a load, a play or a
// tick. A tick's output beat passes the table RAM and output register: the
// trigger and index logic settle the table address before the accepting
// edge, the table RAM registers the word at that edge together with the
// tick's context, and the output register takes the selected fields once
// out_free is high. Throughput is one beat per cycle, set by the one write
// and one read that the table RAM serves each cycle. The input stalls only
// while a tick waits for the table word and the output register is held by
// out_stall. Reset does not clear the table, and ticks read unloaded
// entries too. Loads, plays and undefined requests produce no output beat.
`include "triggered_waveform_sequencer_defines.svh"

module triggered_waveform_sequencer (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [15:0]        entry_index,
  input  logic [15:0]        entry_intensity,
  input  logic signed [15:0] entry_x,
  input  logic signed [15:0] entry_y,
  input  logic signed [15:0] entry_z,
  input  logic [1:0]         play_mode,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_intensity,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic [1:0]         trigger_edge,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_PLAY = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    MODE_BOTH      = 2'd0,
    MODE_INTENSITY = 2'd1,
    MODE_POSITION  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd2
  } edge_t;

  tws_pkg::cfg_t cfg;

  // Sequencer state
  logic [15:0]                  play_index, play_index_next;
  logic                         emitting, emitting_next;
  logic [1:0]                   active_mode, active_mode_next;
  logic                         trigger_high, trigger_high_next;
  logic [tws_pkg::TICK_BITS-1:0] elapsed_ticks, elapsed_ticks_next;

  // Trigger stage results
  logic [15:0] idx_trig;
  logic        emit_trig;
  logic        trig_restart;
  logic [1:0]  edge_code;
  logic [16:0] eff_count;
  logic [16:0] index_inc;
  logic [31:0] t_ext, rise_ext, fall_ext, period_ext;

  // Handshake
  logic in_acc, tick_acc, out_free;

  // Second stage, waiting on the table read
  logic        s2_valid;
  logic        s2_emit;
  logic        s2_rd_ok;
  logic [1:0]  s2_mode;
  logic [1:0]  s2_edge;

  // Table access
  logic                          ram_we, ram_re;
  logic [tws_pkg::ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [63:0]                   ram_wdata, ram_rdata;
  logic [15:0]                   load_int;
  logic                          rd_ok;

  // Output assembly
  logic [15:0] res_i, res_x, res_y, res_z;

  tws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the second stage frees when the output register can take it
  assign out_free = !out_valid || !out_stall;
  assign in_stall = s2_valid && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && (req_type == REQ_TICK);

  // Clamp the playback length
  always_comb begin
    if (cfg.sample_count == 17'd0) begin
      eff_count = 17'd1;
    end else if (cfg.sample_count > tws_pkg::COUNT_CAP) begin
      eff_count = tws_pkg::COUNT_CAP;
    end else begin
      eff_count = cfg.sample_count;
    end
  end

  assign t_ext      = 32'(elapsed_ticks);
  assign rise_ext   = 32'(cfg.trigger_rise_ticks);
  assign fall_ext   = 32'(cfg.trigger_fall_ticks);
  assign period_ext = 32'(cfg.trigger_period_ticks);

  // Trigger gating on the current elapsed count, first match wins
  always_comb begin
    idx_trig          = play_index;
    emit_trig         = emitting;
    trigger_high_next = trigger_high;
    trig_restart      = 1'b0;
    edge_code         = EDGE_NONE;
    if (cfg.trigger_enable) begin
      if (t_ext < rise_ext && emitting) begin
        emit_trig = 1'b0;
      end else if (t_ext >= rise_ext && t_ext < fall_ext && !trigger_high) begin
        edge_code         = EDGE_RISE;
        trigger_high_next = 1'b1;
        idx_trig          = '0;
        emit_trig         = 1'b1;
      end else if (t_ext >= fall_ext && t_ext < period_ext && trigger_high) begin
        edge_code         = EDGE_FALL;
        trigger_high_next = 1'b0;
        emit_trig         = 1'b0;
      end else if (t_ext >= period_ext) begin
        trig_restart = 1'b1;
      end
    end
  end

  assign index_inc = {1'b0, idx_trig} + 17'd1;
  assign rd_ok     = 32'(idx_trig) < 32'(tws_pkg::TABLE_DEPTH);

  // Next state per request kind
  always_comb begin
    play_index_next    = play_index;
    emitting_next      = emitting;
    active_mode_next   = active_mode;
    elapsed_ticks_next = elapsed_ticks;
    case (req_type)
      REQ_PLAY: begin
        active_mode_next = play_mode;
        play_index_next  = '0;
        emitting_next    = 1'b1;
      end
      REQ_TICK: begin
        if (index_inc >= eff_count) begin
          play_index_next = '0;
          emitting_next   = 1'b0;
        end else begin
          play_index_next = index_inc[15:0];
          emitting_next   = emit_trig;
        end
        if (trig_restart) begin
          elapsed_ticks_next = '0;
        end else if (elapsed_ticks != tws_pkg::TICK_MAX) begin
          elapsed_ticks_next = elapsed_ticks + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold sequencer state, advance on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      play_index    <= '0;
      emitting      <= 1'b0;
      active_mode   <= MODE_BOTH;
      trigger_high  <= 1'b0;
      elapsed_ticks <= '0;
    end else if (in_acc) begin
      play_index    <= play_index_next;
      emitting      <= emitting_next;
      active_mode   <= active_mode_next;
      elapsed_ticks <= elapsed_ticks_next;
      if (req_type == REQ_TICK) begin
        trigger_high <= trigger_high_next;
      end
    end
  end

  // Load: saturate intensity, keep the upper sample bits
  assign load_int  = (entry_intensity > tws_pkg::FULL_SCALE) ? tws_pkg::FULL_SCALE
                                                             : entry_intensity;
  assign ram_wdata = {$unsigned(entry_z) & tws_pkg::KEEP_MASK,
                      $unsigned(entry_y) & tws_pkg::KEEP_MASK,
                      $unsigned(entry_x) & tws_pkg::KEEP_MASK,
                      load_int & tws_pkg::KEEP_MASK};
  assign ram_we    = in_acc && (req_type == REQ_LOAD) &&
                     (32'(entry_index) < 32'(tws_pkg::TABLE_DEPTH));
  assign ram_waddr = tws_pkg::ADDR_BITS'(entry_index);
  assign ram_re    = tick_acc;
  assign ram_raddr = tws_pkg::ADDR_BITS'(idx_trig);

  tws_ram #(
    .WIDTH (64),
    .DEPTH (tws_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Second stage: hold tick context while the table word arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_acc) begin
      s2_valid <= (req_type == REQ_TICK);
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s2_emit  <= emit_trig;
      s2_rd_ok <= rd_ok;
      s2_mode  <= active_mode;
      s2_edge  <= edge_code;
    end
  end

  // Select output fields by mode; zero when idle
  always_comb begin
    res_i = '0;
    res_x = '0;
    res_y = '0;
    res_z = '0;
    if (s2_emit && s2_rd_ok) begin
      case (s2_mode)
        MODE_BOTH: begin
          res_i = ram_rdata[15:0];
          res_x = ram_rdata[31:16];
          res_y = ram_rdata[47:32];
          res_z = ram_rdata[63:48];
        end
        MODE_INTENSITY: begin
          res_i = ram_rdata[15:0];
          res_z = tws_pkg::FIXED_Z;
        end
        MODE_POSITION: begin
          res_i = tws_pkg::FULL_SCALE;
          res_x = ram_rdata[31:16];
          res_y = ram_rdata[47:32];
          res_z = ram_rdata[63:48];
        end
        default: ;
      endcase
    end else if (s2_emit) begin
      // index past the table reads as zero, fixed fields still apply
      case (s2_mode)
        MODE_INTENSITY: res_z = tws_pkg::FIXED_Z;
        MODE_POSITION:  res_i = tws_pkg::FULL_SCALE;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_intensity <= res_i;
      out_x         <= $signed(res_x);
      out_y         <= $signed(res_y);
      out_z         <= $signed(res_z);
      trigger_edge  <= s2_edge;
    end
  end

  // Checks
  `TWS_ASSERT_NEXT(a_tick_reaches_s2, tick_acc, s2_valid, "tick beat lost after acceptance")
  `TWS_ASSERT_NEXT(a_s2_held, s2_valid && !out_free, s2_valid, "pending tick dropped")
  `TWS_ASSERT_NOW(a_intensity_range, out_valid, out_intensity <= tws_pkg::FULL_SCALE,
                  "output intensity above full scale")
  `TWS_ASSERT_NEXT(a_ticks_saturate,
                   tick_acc && !trig_restart && elapsed_ticks == tws_pkg::TICK_MAX,
                   elapsed_ticks == tws_pkg::TICK_MAX, "elapsed tick count wrapped")

endmodule
